### src/spq_pkg.sv
// Shared types, codes and defaults for the stable priority task queue.
// No dependencies; used by spq_cell and stable_priority_task_queue_core.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    typedef struct packed {
        logic   insert;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctl;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [PRIO_W-1:0]  head_priority;
        logic [COUNT_W-1:0] count;
    } t_out_item;

endpackage

### src/stable_priority_task_queue_core.sv
// Top level of the stable priority task queue: a chain of spq_cell slots
// plus the entry count and result register. Depends on spq_pkg, spq_cell.
`timescale 1ns / 1ps

// On each transfer all slots compare the new priority at once and shift in
// the same clock edge, so busy never rises and a command may be
// issued every cycle. The result appears on o_result with o_done high in the
// cycle after the transfer, for that one cycle only, and must be taken then.
// It reports the front entry and count after the command; ties keep arrival
// order.
module stable_priority_task_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::t_in_item  i_item,
    output logic               o_done,
    output spq_pkg::t_out_item o_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic               r_done;
    spq_pkg::t_status   r_status;
    logic [CW-1:0]      r_count;
    logic               n_done;
    spq_pkg::t_status   n_status;
    logic [CW-1:0]      n_count;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_ctl w_ctl;
    spq_pkg::t_slot     w_slot [CAPACITY];
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_valid;
    logic [CW+4:0]      w_count_ext;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_ctl.insert    = w_accept && (i_item.op == spq_pkg::OP_INSERT) && !w_full;
        w_ctl.pop       = w_accept && (i_item.op == spq_pkg::OP_POP) && !w_empty;
        w_ctl.new_entry = '{id: i_item.task_id, prio: i_item.priority_req};
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            spq_pkg::t_slot prev_slot;
            spq_pkg::t_slot next_slot;
            logic           prev_gt;

            if (g == 0) begin : g_first
                assign prev_slot = '{valid: 1'b1, entry: '0};
                assign prev_gt   = 1'b0;
            end else begin : g_mid
                assign prev_slot = w_slot[g-1];
                assign prev_gt   = w_gt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign next_slot = '{valid: 1'b0, entry: '0};
            end else begin : g_body
                assign next_slot = w_slot[g+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_prev    (prev_slot),
                .i_prev_gt (prev_gt),
                .i_next    (next_slot),
                .o_slot    (w_slot[g]),
                .o_gt      (w_gt[g])
            );

            assign w_valid[g] = w_slot[g].valid;
        end
    endgenerate

    always_comb begin
        n_done   = w_accept;
        n_status = r_status;
        n_count  = r_count;
        if (w_accept) begin
            unique case (i_item.op)
                spq_pkg::OP_INSERT: begin
                    n_status = w_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
                    n_count  = w_full ? r_count : r_count + CW'(1);
                end
                spq_pkg::OP_POP: begin
                    n_status = w_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
                    n_count  = w_empty ? r_count : r_count - CW'(1);
                end
                default: begin
                    n_status = r_status;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_status <= n_status;
    end

    assign w_count_ext = {5'd0, r_count};

    always_comb begin
        o_result.status        = r_status;
        o_result.head_valid    = w_slot[0].valid;
        o_result.head_id       = w_slot[0].valid ? w_slot[0].entry.id : '0;
        o_result.head_priority = w_slot[0].valid ? w_slot[0].entry.prio : '0;
        o_result.count         = w_count_ext[spq_pkg::COUNT_W-1:0];
    end

    assign o_done = r_done;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("result strobe missing after transfer");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("slot valid bits disagree with entry count");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + CAPACITY'(1))) == '0)
        else $error("valid slots not packed at the front");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_status == spq_pkg::ST_FULL)) |-> w_full)
        else $error("full refusal with free slots");

endmodule

### src/spq_cell.sv
// One slot of the sorted queue chain: holds an entry and its valid bit.
// Depends on spq_pkg; instantiated by stable_priority_task_queue_core.
`timescale 1ns / 1ps

module spq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_slot    i_prev,
    input  logic              i_prev_gt,
    input  spq_pkg::t_slot    i_next,
    output spq_pkg::t_slot    o_slot,
    output logic              o_gt
);

    logic           r_valid;
    spq_pkg::t_entry r_entry;
    logic           n_valid;
    spq_pkg::t_entry n_entry;

    assign o_gt   = r_valid && (r_entry.prio > i_ctl.new_entry.prio);
    assign o_slot = '{valid: r_valid, entry: r_entry};

    always_comb begin
        priority if (i_ctl.pop) begin
            n_valid = i_next.valid;
            n_entry = i_next.entry;
        end else if (i_ctl.insert && i_prev_gt) begin
            n_valid = 1'b1;
            n_entry = i_prev.entry;
        end else if (i_ctl.insert && (o_gt || (!r_valid && i_prev.valid))) begin
            n_valid = 1'b1;
            n_entry = i_ctl.new_entry;
        end else begin
            n_valid = r_valid;
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

endmodule

### tb/stable_priority_task_queue_core_tb.sv
// Self-checking testbench for stable_priority_task_queue_core: a directed table,
// then random insert/pop traffic checked against a behavioral sorted queue.
// Depends on spq_pkg and the stable_priority_task_queue_core RTL.
`timescale 1ns / 1ps

module stable_priority_task_queue_core_tb;

    localparam int CAP         = spq_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int RAND_BLOCKS = 17;
    localparam int BLOCK_LEN   = 100;

    typedef struct {
        spq_pkg::t_in_item  cmd;
        bit                 typed;
        spq_pkg::t_out_item res;
    } t_cmd_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    spq_pkg::t_in_item  i_item  = '0;
    logic               busy;
    logic               o_done;
    spq_pkg::t_out_item o_result;

    logic [spq_pkg::ID_W-1:0]   sorted_ids   [CAP];
    logic [spq_pkg::PRIO_W-1:0] sorted_prios [CAP];
    int                         sorted_count = 0;

    spq_pkg::t_out_item pending_results [$];
    t_cmd_row           cmd_table [$];
    spq_pkg::t_out_item want;
    int                 mismatches = 0;
    int                 cycle_cnt  = 0;

    stable_priority_task_queue_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic spq_pkg::t_out_item next_queue_result(spq_pkg::t_in_item cmd);
        spq_pkg::t_out_item r;
        int                 pos;
        r = '0;
        r.status = spq_pkg::ST_OK;
        if (cmd.op == spq_pkg::OP_INSERT) begin
            if (sorted_count >= CAP) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_count && sorted_prios[pos] <= cmd.priority_req) pos++;
                for (int k = sorted_count; k > pos; k--) begin
                    sorted_ids[k]   = sorted_ids[k-1];
                    sorted_prios[k] = sorted_prios[k-1];
                end
                sorted_ids[pos]   = cmd.task_id;
                sorted_prios[pos] = cmd.priority_req;
                sorted_count++;
            end
        end else begin
            if (sorted_count == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                for (int k = 1; k < sorted_count; k++) begin
                    sorted_ids[k-1]   = sorted_ids[k];
                    sorted_prios[k-1] = sorted_prios[k];
                end
                sorted_count--;
            end
        end
        if (sorted_count > 0) begin
            r.head_valid    = 1'b1;
            r.head_id       = sorted_ids[0];
            r.head_priority = sorted_prios[0];
        end
        r.count = spq_pkg::COUNT_W'(sorted_count);
        return r;
    endfunction

    function automatic spq_pkg::t_out_item result_of(spq_pkg::t_status st, logic v,
                                                     logic [spq_pkg::ID_W-1:0] id,
                                                     logic [spq_pkg::PRIO_W-1:0] prio,
                                                     int cnt);
        spq_pkg::t_out_item r;
        r.status        = st;
        r.head_valid    = v;
        r.head_id       = id;
        r.head_priority = prio;
        r.count         = spq_pkg::COUNT_W'(cnt);
        return r;
    endfunction

    function automatic spq_pkg::t_in_item rand_cmd(int insert_pct);
        spq_pkg::t_in_item c;
        int                sel;
        c.op      = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT
                                                         : spq_pkg::OP_POP;
        c.task_id = spq_pkg::ID_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        if (sel < 4)
            c.priority_req = spq_pkg::PRIO_W'($urandom_range(0, 3));
        else if (sel == 4)
            c.priority_req = '0;
        else if (sel == 5)
            c.priority_req = '1;
        else if (sel == 6)
            c.priority_req = spq_pkg::PRIO_W'($urandom_range(252, 255));
        else
            c.priority_req = spq_pkg::PRIO_W'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, int got, int exp_val);
        if (got != exp_val)
            report($sformatf("%s got %0d expected %0d", name, got, exp_val));
    endtask

    task automatic add_row(spq_pkg::t_op op, logic [spq_pkg::ID_W-1:0] id,
                           logic [spq_pkg::PRIO_W-1:0] prio,
                           bit typed, spq_pkg::t_out_item res);
        t_cmd_row row;
        row.cmd.op           = op;
        row.cmd.task_id      = id;
        row.cmd.priority_req = prio;
        row.typed            = typed;
        row.res              = res;
        cmd_table.push_back(row);
    endtask

    // Hold the command until the transfer, then record what it must produce.
    task automatic send_cmd(spq_pkg::t_in_item cmd, bit typed,
                            spq_pkg::t_out_item typed_res);
        spq_pkg::t_out_item pred;
        i_item <= cmd;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        pred = next_queue_result(cmd);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic idle_gap(bit no_idle);
        int n;
        int sel;
        n = 0;
        if (!no_idle) begin
            sel = $urandom_range(0, 19);
            if (sel < 8)
                n = 0;
            else if (sel < 18)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(10, 40);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report("result with no pending command");
            end else begin
                want = pending_results.pop_front();
                check_field("status", o_result.status, want.status);
                check_field("head_valid", o_result.head_valid, want.head_valid);
                check_field("head_id", o_result.head_id, want.head_id);
                check_field("head_priority", o_result.head_priority, want.head_priority);
                check_field("count", o_result.count, want.count);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int insert_pct;
        bit no_idle;

        add_row(spq_pkg::OP_POP,    8'hFF, 8'hFF, 1,
                result_of(spq_pkg::ST_EMPTY, 1'b0, 8'h00, 8'h00, 0));
        add_row(spq_pkg::OP_INSERT, 8'hAA, 8'hFF, 1,
                result_of(spq_pkg::ST_OK,    1'b1, 8'hAA, 8'hFF, 1));
        add_row(spq_pkg::OP_INSERT, 8'h55, 8'h00, 1,
                result_of(spq_pkg::ST_OK,    1'b1, 8'h55, 8'h00, 2));
        add_row(spq_pkg::OP_INSERT, 8'h01, 8'h00, 1,
                result_of(spq_pkg::ST_OK,    1'b1, 8'h55, 8'h00, 3));
        add_row(spq_pkg::OP_POP,    8'h00, 8'h00, 1,
                result_of(spq_pkg::ST_OK,    1'b1, 8'h01, 8'h00, 2));
        add_row(spq_pkg::OP_POP,    8'h00, 8'h00, 1,
                result_of(spq_pkg::ST_OK,    1'b1, 8'hAA, 8'hFF, 1));
        add_row(spq_pkg::OP_POP,    8'h00, 8'h00, 1,
                result_of(spq_pkg::ST_OK,    1'b0, 8'h00, 8'h00, 0));
        add_row(spq_pkg::OP_POP,    8'h00, 8'h00, 1,
                result_of(spq_pkg::ST_EMPTY, 1'b0, 8'h00, 8'h00, 0));
        for (int k = 0; k < CAP; k++)
            add_row(spq_pkg::OP_INSERT, spq_pkg::ID_W'(k * 17), 8'h80, 0, '0);
        add_row(spq_pkg::OP_INSERT, 8'hFF, 8'h00, 1,
                result_of(spq_pkg::ST_FULL, 1'b1, 8'h00, 8'h80, CAP));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (cmd_table[i]) begin
            send_cmd(cmd_table[i].cmd, cmd_table[i].typed, cmd_table[i].res);
            idle_gap(1'b0);
        end

        for (int b = 0; b < RAND_BLOCKS; b++) begin
            case ($urandom_range(0, 3))
                0: insert_pct = 15;
                1: insert_pct = 50;
                2: insert_pct = 85;
                default: insert_pct = 60;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCK_LEN; n++) begin
                send_cmd(rand_cmd(insert_pct), 0, '0);
                idle_gap(no_idle);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_task_queue_core.sv
tb/stable_priority_task_queue_core_tb.sv
